[design/assert_macros.svh]
// Assertion macros shared by the change event unit.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define HRCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define HRCE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[design/hrce_pkg.sv]
// Shared types and constants of the report change event unit.
// Depends on nothing; used by the front, the job queue, the back and the top level.
package hrce_pkg;

  localparam int ReportLen  = 14;
  localparam int HalfLen    = 8;
  localparam int ButtonBits = 34;

  // Event kinds as they appear on the output.
  typedef enum logic [2:0] {
    KindAxes    = 3'd0,
    KindHat     = 3'd1,
    KindBtnDown = 3'd2,
    KindBtnUp   = 3'd3,
    KindMouse   = 3'd4
  } hrce_kind_e;

  // One packet part as it arrives.
  typedef struct packed {
    logic [3:0]      byte_count;
    logic [7:0][7:0] bytes;
  } hrce_part_t;

  // Everything the back needs to emit the events of one evaluation.
  typedef struct packed {
    logic                  axes_chg;
    logic [10:0]           axis_x;
    logic [10:0]           axis_y;
    logic [9:0]            axis_rz;
    logic [7:0]            axis_z;
    logic [7:0]            axis_rx;
    logic [7:0]            axis_ry;
    logic [7:0]            axis_slider;
    logic                  hat_chg;
    logic [3:0]            hat;
    logic [ButtonBits-1:0] btn_chg;
    logic [ButtonBits-1:0] btn_val;
    logic                  mouse_chg;
    logic [7:0]            mouse;
  } hrce_job_t;

endpackage

[design/hrce_front.sv]
// Front of the change event unit: stores report halves and classifies changes.
// Depends on hrce_pkg and assert_macros.svh; feeds jobs to hrce_job_fifo.
`include "assert_macros.svh"

module hrce_front #(
  parameter int BUTTON_COUNT = 34
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hrce_pkg::hrce_part_t part_i,
  input  logic                fifo_full_i,
  output logic                push_o,
  output hrce_pkg::hrce_job_t job_o
);
  import hrce_pkg::*;

  localparam logic [ButtonBits-1:0] BtnEnMask =
    ButtonBits'((35'd1 << BUTTON_COUNT) - 35'd1);

  logic [ReportLen-1:0][7:0] rpt_q, rpt_d;
  logic [ReportLen-1:0][7:0] merged;
  logic [63:0]               prev_axes_q, prev_axes_d;
  logic [3:0]                prev_hat_q, prev_hat_d;
  logic [ButtonBits-1:0]     prev_btn_q, prev_btn_d;
  logic [7:0]                prev_mouse_q, prev_mouse_d;
  logic [3:0]                cnt_sat;
  logic                      first_half;
  logic                      accept;
  logic [63:0]               axes_now;
  logic [ButtonBits-1:0]     buttons;
  logic                      any_event;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Saturate the count and merge a second part into bytes 8 onward.
  always_comb begin
    cnt_sat    = (part_i.byte_count > 4'(HalfLen)) ? 4'(HalfLen) : part_i.byte_count;
    first_half = (cnt_sat == 4'(HalfLen));
    merged     = rpt_q;
    for (int j = 0; j < ReportLen - HalfLen; j++) begin
      if (4'(j) < cnt_sat) begin
        merged[HalfLen + j] = part_i.bytes[j];
      end
    end
  end

  // Compare the merged report against the remembered values.
  always_comb begin
    axes_now = rpt_q[HalfLen-1:0];
    buttons  = {merged[12][1:0], merged[11], merged[10], merged[9], merged[8]};

    job_o.axes_chg    = (axes_now != prev_axes_q);
    job_o.axis_x      = {rpt_q[1][2:0], rpt_q[0]};
    job_o.axis_y      = {rpt_q[2][5:0], rpt_q[1][7:3]};
    job_o.axis_rz     = {rpt_q[3], rpt_q[2][7:6]};
    job_o.axis_z      = rpt_q[4];
    job_o.axis_rx     = rpt_q[5];
    job_o.axis_ry     = rpt_q[6];
    job_o.axis_slider = rpt_q[7];
    job_o.hat         = merged[12][7:4];
    job_o.hat_chg     = (merged[12][7:4] != prev_hat_q);
    job_o.btn_chg     = (buttons ^ prev_btn_q) & BtnEnMask;
    job_o.btn_val     = buttons;
    job_o.mouse       = merged[13];
    job_o.mouse_chg   = (merged[13] != prev_mouse_q);

    any_event = job_o.axes_chg || job_o.hat_chg || (|job_o.btn_chg) || job_o.mouse_chg;
    push_o    = accept && !first_half && any_event;
  end

  // Next state of the report and the remembered values.
  always_comb begin
    rpt_d        = rpt_q;
    prev_axes_d  = prev_axes_q;
    prev_hat_d   = prev_hat_q;
    prev_btn_d   = prev_btn_q;
    prev_mouse_d = prev_mouse_q;
    if (accept) begin
      if (first_half) begin
        rpt_d[HalfLen-1:0] = part_i.bytes;
      end else begin
        rpt_d        = merged;
        prev_axes_d  = axes_now;
        prev_hat_d   = merged[12][7:4];
        prev_btn_d   = buttons;
        prev_mouse_d = merged[13];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpt_q        <= '0;
      prev_axes_q  <= '0;
      prev_hat_q   <= '0;
      prev_btn_q   <= '0;
      prev_mouse_q <= '0;
    end else begin
      rpt_q        <= rpt_d;
      prev_axes_q  <= prev_axes_d;
      prev_hat_q   <= prev_hat_d;
      prev_btn_q   <= prev_btn_d;
      prev_mouse_q <= prev_mouse_d;
    end
  end

  // After an evaluation the remembered hat follows the stored report.
  `HRCE_ASSERT(a_hat_tracks_report, (accept && !first_half) |=> (prev_hat_q == rpt_q[12][7:4]), "hat memory does not follow report")

endmodule

[design/hrce_job_fifo.sv]
// Short job queue between the front and the back of the change event unit.
// Depends on hrce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hrce_job_fifo #(
  parameter int Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hrce_pkg::hrce_job_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output hrce_pkg::hrce_job_t data_o
);
  import hrce_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  hrce_job_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `HRCE_ASSERT(a_count_bounded, (count_q <= CntW'(Depth)), "job queue count above depth")

endmodule

[design/hrce_back.sv]
// Back of the change event unit: turns one job into a run of serialized events.
// Depends on hrce_pkg and assert_macros.svh; takes jobs from hrce_job_fifo.
`include "assert_macros.svh"

module hrce_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  hrce_pkg::hrce_job_t job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          event_kind_o,
  output logic [10:0]         axis_x_o,
  output logic [10:0]         axis_y_o,
  output logic [9:0]          axis_rz_o,
  output logic [7:0]          axis_z_o,
  output logic [7:0]          axis_rx_o,
  output logic [7:0]          axis_ry_o,
  output logic [7:0]          axis_slider_o,
  output logic [7:0]          event_code_o,
  output logic                last_of_run_o
);
  import hrce_pkg::*;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e                state_q, state_d;
  hrce_job_t             job_q, job_d;
  logic                  out_valid_q, out_valid_d;
  hrce_kind_e            kind_q, kind_d;
  logic [10:0]           ax_x_q, ax_x_d, ax_y_q, ax_y_d;
  logic [9:0]            ax_rz_q, ax_rz_d;
  logic [7:0]            ax_z_q, ax_z_d, ax_rx_q, ax_rx_d;
  logic [7:0]            ax_ry_q, ax_ry_d, ax_sl_q, ax_sl_d;
  logic [7:0]            code_q, code_d;
  logic                  last_q, last_d;
  logic                  can_emit;
  logic [ButtonBits-1:0] btn_low, btn_rest;
  logic [7:0]            btn_idx;

  assign can_emit = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == StIdle) && !empty_i;

  // Lowest pending button, its index and the mask without it.
  always_comb begin
    btn_low  = job_q.btn_chg & (~job_q.btn_chg + ButtonBits'(1));
    btn_rest = job_q.btn_chg & (job_q.btn_chg - ButtonBits'(1));
    btn_idx  = '0;
    for (int i = 0; i < ButtonBits; i++) begin
      if (btn_low[i]) begin
        btn_idx = btn_idx | 8'(i);
      end
    end
  end

  // Pick the next event in the order axes, hat, buttons, mouse and load it into the output register.
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    ax_x_d      = ax_x_q;
    ax_y_d      = ax_y_q;
    ax_rz_d     = ax_rz_q;
    ax_z_d      = ax_z_q;
    ax_rx_d     = ax_rx_q;
    ax_ry_d     = ax_ry_q;
    ax_sl_d     = ax_sl_q;
    code_d      = code_q;
    last_d      = last_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          job_d   = job_i;
          state_d = StRun;
        end
      end
      StRun: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          ax_x_d      = '0;
          ax_y_d      = '0;
          ax_rz_d     = '0;
          ax_z_d      = '0;
          ax_rx_d     = '0;
          ax_ry_d     = '0;
          ax_sl_d     = '0;
          code_d      = '0;
          priority if (job_q.axes_chg) begin
            kind_d         = KindAxes;
            ax_x_d         = job_q.axis_x;
            ax_y_d         = job_q.axis_y;
            ax_rz_d        = job_q.axis_rz;
            ax_z_d         = job_q.axis_z;
            ax_rx_d        = job_q.axis_rx;
            ax_ry_d        = job_q.axis_ry;
            ax_sl_d        = job_q.axis_slider;
            job_d.axes_chg = 1'b0;
          end else if (job_q.hat_chg) begin
            kind_d        = KindHat;
            code_d        = {4'd0, job_q.hat};
            job_d.hat_chg = 1'b0;
          end else if (|job_q.btn_chg) begin
            kind_d        = (|(job_q.btn_val & btn_low)) ? KindBtnDown : KindBtnUp;
            code_d        = btn_idx;
            job_d.btn_chg = btn_rest;
          end else begin
            kind_d          = KindMouse;
            code_d          = job_q.mouse;
            job_d.mouse_chg = 1'b0;
          end
          last_d = !(job_d.axes_chg || job_d.hat_chg || (|job_d.btn_chg) ||
                     job_d.mouse_chg);
          if (last_d) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      job_q       <= '0;
      kind_q      <= KindAxes;
      ax_x_q      <= '0;
      ax_y_q      <= '0;
      ax_rz_q     <= '0;
      ax_z_q      <= '0;
      ax_rx_q     <= '0;
      ax_ry_q     <= '0;
      ax_sl_q     <= '0;
      code_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      job_q       <= job_d;
      kind_q      <= kind_d;
      ax_x_q      <= ax_x_d;
      ax_y_q      <= ax_y_d;
      ax_rz_q     <= ax_rz_d;
      ax_z_q      <= ax_z_d;
      ax_rx_q     <= ax_rx_d;
      ax_ry_q     <= ax_ry_d;
      ax_sl_q     <= ax_sl_d;
      code_q      <= code_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign axis_x_o      = ax_x_q;
  assign axis_y_o      = ax_y_q;
  assign axis_rz_o     = ax_rz_q;
  assign axis_z_o      = ax_z_q;
  assign axis_rx_o     = ax_rx_q;
  assign axis_ry_o     = ax_ry_q;
  assign axis_slider_o = ax_sl_q;
  assign event_code_o  = code_q;
  assign last_of_run_o = last_q;

  // A shown event that is not the last of its run leaves the job in progress.
  `HRCE_ASSERT(a_run_continues, ((out_valid_q && !last_q) |-> (state_q == StRun)), "run ended without a last event")

endmodule

[design/hid_report_change_events_unit.sv]
// Top level of the joystick report change event unit.
// Depends on hrce_pkg, hrce_front, hrce_job_fifo and hrce_back.
//
// Usage: packet parts enter on the input channel (in_valid_i / in_stall_o)
// with byte_count_i and part_byte_0_i..part_byte_7_i. A part of eight bytes
// (or a count above eight) is stored as the first report half and causes no
// events. A shorter part fills bytes 8 onward, up to 13, and starts an evaluation.
// Events leave on the output channel (out_valid_o / out_stall_i) in the order
// axes, hat, buttons in ascending index, mouse; last_of_run_o marks the final
// event of an evaluation. An evaluation with no change gives no events.
// A part's first event passes the job queue, job register and output register.
// Throughput: the back emits one event per cycle while the output is not
// stalled, and it loads each job in its idle state, where it emits no event. The
// front takes one part per cycle while the job queue (JOB_DEPTH entries) has
// room; it stalls when the queue is full.
// A stalled output holds its event; the back waits and the queue fills.
// Reset clears the stored report and all remembered values to zero at once.
module hid_report_change_events_unit #(
  parameter int BUTTON_COUNT = 34,
  parameter int JOB_DEPTH    = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  byte_count_i,
  input  logic [7:0]  part_byte_0_i,
  input  logic [7:0]  part_byte_1_i,
  input  logic [7:0]  part_byte_2_i,
  input  logic [7:0]  part_byte_3_i,
  input  logic [7:0]  part_byte_4_i,
  input  logic [7:0]  part_byte_5_i,
  input  logic [7:0]  part_byte_6_i,
  input  logic [7:0]  part_byte_7_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [10:0] axis_x_o,
  output logic [10:0] axis_y_o,
  output logic [9:0]  axis_rz_o,
  output logic [7:0]  axis_z_o,
  output logic [7:0]  axis_rx_o,
  output logic [7:0]  axis_ry_o,
  output logic [7:0]  axis_slider_o,
  output logic [7:0]  event_code_o,
  output logic        last_of_run_o
);
  import hrce_pkg::*;

  hrce_part_t part;
  hrce_job_t  push_job;
  hrce_job_t  pop_job;
  logic       push;
  logic       pop;
  logic       fifo_full;
  logic       fifo_empty;

  // Gather the part bytes, byte 0 in the lowest lane.
  assign part.byte_count = byte_count_i;
  assign part.bytes      = {part_byte_7_i, part_byte_6_i, part_byte_5_i, part_byte_4_i,
                            part_byte_3_i, part_byte_2_i, part_byte_1_i, part_byte_0_i};

  hrce_front #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .part_i     (part),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  hrce_job_fifo #(
    .Depth(JOB_DEPTH)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .full_o (fifo_full),
    .pop_i  (pop),
    .empty_o(fifo_empty),
    .data_o (pop_job)
  );

  hrce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (fifo_empty),
    .job_i        (pop_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .axis_x_o     (axis_x_o),
    .axis_y_o     (axis_y_o),
    .axis_rz_o    (axis_rz_o),
    .axis_z_o     (axis_z_o),
    .axis_rx_o    (axis_rx_o),
    .axis_ry_o    (axis_ry_o),
    .axis_slider_o(axis_slider_o),
    .event_code_o (event_code_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule
